// File: rtl/core/dtc_pkg.sv
package dtc_pkg;

  // screen geometry
  localparam int Columns = 80;

  localparam int ColW    = 7;
  localparam int RowW    = 5;
  localparam int NumW    = 32;
  localparam int AddrW   = 11;
  localparam int WordW   = 16;
  localparam int Digits  = 10;
  localparam int BcdW    = 4 * Digits;
  localparam int LeftW   = 4;

  localparam logic [WordW-1:0] ColorReset = 16'h0700;
  localparam logic [WordW-1:0] AsciiZero  = 16'h0030;

  typedef struct packed {
    logic [ColW-1:0] column;
    logic [RowW-1:0] row;
    logic [NumW-1:0] number;
  } in_t;

  typedef struct packed {
    logic [AddrW-1:0] cell_address;
    logic [WordW-1:0] cell_word;
    logic             last_digit;
  } out_t;

endpackage

// File: rtl/core/dtc_dabble.sv
// Shift-and-add-3 binary to BCD, one binary bit per cycle.
module dtc_dabble (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [dtc_pkg::NumW-1:0]  value_i,
  output logic                      done_o,
  output logic [dtc_pkg::BcdW-1:0]  bcd_o
);

  localparam int StepW = $clog2(dtc_pkg::NumW);

  logic [dtc_pkg::NumW-1:0] bin_q;
  logic [dtc_pkg::BcdW-1:0] bcd_q, bcd_adj;
  logic [StepW-1:0]         step_q;
  logic                     busy_q, done_q;

  always_comb begin
    logic [3:0] nib;
    nib = '0;
    for (int i = 0; i < dtc_pkg::Digits; i++) begin
      nib = bcd_q[4*i +: 4];
      bcd_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(dtc_pkg::NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= value_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bin_q <= {bin_q[dtc_pkg::NumW-2:0], 1'b0};
      bcd_q <= {bcd_adj[dtc_pkg::BcdW-2:0], bin_q[dtc_pkg::NumW-1]};
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// File: rtl/core/decimal_to_text_cells.sv
// Decimal number writer for a character-cell text screen.
// Input channel (in_valid_i / in_stall_o / in_data_i): column, row and a
// 32-bit unsigned number. Output channel (out_valid_o / out_stall_i /
// out_data_o): one cell write per decimal digit, most significant first,
// no leading zeros, zero written as a single '0'; last_digit marks the end.
// Cell address is column + digit index + row * 80, kept to 11 bits.
// Cell word is the color attribute ORed with the ASCII digit.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the color
// attribute; always ready, to be written only while idle.
// Operation: bit-serial binary to BCD conversion, then the digits are
// loaded and leading zeros are stripped, keeping at least one digit, then
// one digit per cycle, 1..10 digits in all, while the output is not stalled.
// One request at a time: the input stalls until the last digit sits in the
// output register. A stall on the output holds the current write and
// pauses digit emission.
// Reset: idle, no output valid, color attribute 0x0700.
module decimal_to_text_cells (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  dtc_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output dtc_pkg::out_t              out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [dtc_pkg::WordW-1:0]  cfg_data_i
);

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StSkip,
    StEmit
  } state_e;

  state_e                       state_q;
  logic [dtc_pkg::AddrW-1:0]    addr_q, base_addr;
  logic [dtc_pkg::BcdW-1:0]     digits_q, bcd;
  logic [dtc_pkg::LeftW-1:0]    left_q;
  logic [dtc_pkg::WordW-1:0]    color_q;
  logic                         out_valid_q;
  dtc_pkg::out_t                out_q;
  logic                         accept, dbl_done, load_out;
  logic [3:0]                   top_digit;

  assign accept    = in_valid_i && (state_q == StIdle);
  assign top_digit = digits_q[dtc_pkg::BcdW-1 -: 4];
  assign load_out  = (state_q == StEmit) && (!out_valid_q || !out_stall_i);

  // row * Columns is wanted modulo 2048 only
  assign base_addr = dtc_pkg::AddrW'(in_data_i.column)
                   + dtc_pkg::AddrW'(dtc_pkg::AddrW'(in_data_i.row)
                                     * dtc_pkg::AddrW'(dtc_pkg::Columns));

  dtc_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .value_i (in_data_i.number),
    .done_o  (dbl_done),
    .bcd_o   (bcd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      color_q     <= dtc_pkg::ColorReset;
      left_q      <= '0;
      addr_q      <= '0;
      digits_q    <= '0;
      out_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        color_q <= cfg_data_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            addr_q  <= base_addr;
            state_q <= StConv;
          end
        end
        StConv: begin
          if (dbl_done) begin
            digits_q <= bcd;
            left_q   <= dtc_pkg::LeftW'(dtc_pkg::Digits);
            state_q  <= StSkip;
          end
        end
        StSkip: begin
          // strip leading zeros, keep at least one digit
          if (top_digit == 4'd0 && left_q != dtc_pkg::LeftW'(1)) begin
            digits_q <= {digits_q[dtc_pkg::BcdW-5:0], 4'd0};
            left_q   <= left_q - 1'b1;
          end else begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (load_out) begin
            out_q.cell_address <= addr_q;
            out_q.cell_word    <= color_q | (dtc_pkg::AsciiZero
                                             + dtc_pkg::WordW'(top_digit));
            out_q.last_digit   <= (left_q == dtc_pkg::LeftW'(1));
            addr_q             <= addr_q + 1'b1;
            digits_q           <= {digits_q[dtc_pkg::BcdW-5:0], 4'd0};
            left_q             <= left_q - 1'b1;
            if (left_q == dtc_pkg::LeftW'(1)) begin
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  a_emit_has_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> left_q != '0)
    else $error("emit with no digits left");

  a_last_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && left_q == dtc_pkg::LeftW'(1) |=> out_valid_o && out_data_o.last_digit)
    else $error("final digit not flagged");

  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dbl_done |-> state_q == StConv)
    else $error("conversion finished outside conversion state");

endmodule
